/* hw/rtl/wlcm_pkg.sv */
// Shared types and constants for the window/level color mapper.
package wlcm_pkg;

    // Color table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Field widths fixed by the item formats
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 10;
    localparam int CFG_IDX_W = 3;

    // Fixed-point index arithmetic: Q16.16 sample times Q8.24 scale gives 40 fraction bits
    localparam int FRAC_W = 40;
    localparam int MAG_W  = DATA_W + 1;
    localparam int PROD_W = 64;
    localparam int U_W    = IDX_W + FRAC_W + 4;
    localparam int HI_W   = U_W - 1 - FRAC_W;

    // Products beyond twice the table are capped; the clamp result is unchanged
    localparam logic [U_W-1:0] PROD_CAP   = U_W'(2 * TABLE_ENTRIES) << FRAC_W;
    // Table center plus the rounding half
    localparam logic [U_W-1:0] ROUND_BASE = (U_W'(TABLE_ENTRIES / 2) << FRAC_W)
                                          + (U_W'(1) << (FRAC_W - 1));

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] WINDOW_LEVEL_RST  = 32'h0000_0000;
    localparam logic [DATA_W-1:0] INDEX_SCALE_RST   = 32'h0100_0000;
    localparam logic [DATA_W-1:0] ZERO_COLOR_RST    = 32'h0000_0000;
    localparam logic [DATA_W-1:0] NONZERO_COLOR_RST = 32'h7901_0400;

    // Item functions
    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEVEL  = 3'd0,
        CFG_INDEX_SCALE   = 3'd1,
        CFG_BINARY_MODE   = 3'd2,
        CFG_ZERO_COLOR    = 3'd3,
        CFG_NONZERO_COLOR = 3'd4
    } cfg_index_t;

    // Input beat
    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] pixel_value;
        logic [ADDR_W-1:0]        entry_address;
        logic [DATA_W-1:0]        entry_color;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [DATA_W-1:0] pixel_color;
        logic              saturated;
    } out_item_t;

endpackage

/* hw/rtl/wlcm_ram.sv */
// Generic simple dual-port RAM with registered read.
module wlcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/window_level_color_mapper.sv */
// Window/level color mapper top level: index pipeline, color table and result queue.
//
// Usage:
//   s_valid/s_ready/s_data carry input beats. func selects a map beat (sample in
//   pixel_value, Q16.16) or a table write beat (entry_color at entry_address).
//   m_valid/m_ready/m_data carry one result beat per map beat, in order; write
//   beats give no result. Configuration registers are written through cfg_we,
//   cfg_index and cfg_wdata; the user must do so only while the block is idle,
//   as the block itself does not enforce it. Throughput: one beat per clock
//   while s_ready is high, set by the one-read/one-write color table, which
//   write beats and table map beats visit in order at the same pipeline stage.
//   A result passes difference, multiply, table read and result queue in order.
//   Stalls: an 8-entry result queue follows the pipeline; s_ready drops while
//   8 map results are in flight or queued, so a stalled receiver holds the
//   input side without loss and the pipeline itself never stops.
//   Reset (aresetn low, synchronous): registers return to their reset values,
//   pipeline and queue empty. The color table is not cleared; write an entry
//   before any sample maps onto it.
module window_level_color_mapper
    import wlcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    // configuration port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata
);

    // Configuration registers
    logic [DATA_W-1:0] window_level_reg;
    logic [DATA_W-1:0] index_scale_reg;
    logic              binary_mode_reg;
    logic [DATA_W-1:0] zero_color_reg;
    logic [DATA_W-1:0] nonzero_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_level_reg  <= WINDOW_LEVEL_RST;
            index_scale_reg   <= INDEX_SCALE_RST;
            binary_mode_reg   <= 1'b0;
            zero_color_reg    <= ZERO_COLOR_RST;
            nonzero_color_reg <= NONZERO_COLOR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WINDOW_LEVEL:  window_level_reg  <= cfg_wdata;
                CFG_INDEX_SCALE:   index_scale_reg   <= cfg_wdata;
                CFG_BINARY_MODE:   binary_mode_reg   <= cfg_wdata[0];
                CFG_ZERO_COLOR:    zero_color_reg    <= cfg_wdata;
                CFG_NONZERO_COLOR: nonzero_color_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshakes and result credit count
    logic                  s_fire;
    logic                  m_fire;
    logic                  map_fire;
    logic [FIFO_CNT_W-1:0] occ_reg;
    logic [FIFO_CNT_W-1:0] occ_next;

    assign s_ready  = (occ_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign map_fire = s_fire && (s_data.func == FUNC_MAP);

    always_comb begin
        occ_next = occ_reg;
        if (map_fire && !m_fire) begin
            occ_next = occ_reg + FIFO_CNT_W'(1);
        end else if (!map_fire && m_fire) begin
            occ_next = occ_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Stage A: signed difference magnitude, both orders in parallel
    logic [MAG_W-1:0] diff_pl;
    logic [MAG_W-1:0] diff_lp;
    logic             a_valid_reg;
    logic             a_func_reg;
    logic             a_neg_reg;
    logic             a_bin_reg;
    logic [MAG_W-1:0] a_mag_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [DATA_W-1:0] a_color_reg;

    assign diff_pl = {s_data.pixel_value[DATA_W-1], s_data.pixel_value}
                   - {window_level_reg[DATA_W-1], window_level_reg};
    assign diff_lp = {window_level_reg[DATA_W-1], window_level_reg}
                   - {s_data.pixel_value[DATA_W-1], s_data.pixel_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        a_func_reg <= s_data.func;
        a_neg_reg  <= diff_pl[MAG_W-1];
        a_mag_reg  <= diff_pl[MAG_W-1] ? diff_lp : diff_pl;
        a_bin_reg  <= binary_mode_reg;
        a_addr_reg <= s_data.entry_address;
        // write beats carry the entry color, binary map beats their fixed color
        if (s_data.func == FUNC_WRITE) begin
            a_color_reg <= s_data.entry_color;
        end else if (s_data.pixel_value == '0) begin
            a_color_reg <= zero_color_reg;
        end else begin
            a_color_reg <= nonzero_color_reg;
        end
    end

    // Stage B: magnitude times scale
    logic              b_valid_reg;
    logic              b_func_reg;
    logic              b_neg_reg;
    logic              b_bin_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [DATA_W-1:0] b_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b_func_reg  <= a_func_reg;
        b_neg_reg   <= a_neg_reg;
        b_bin_reg   <= a_bin_reg;
        b_prod_reg  <= {(PROD_W - MAG_W)'(0), a_mag_reg}
                     * {(PROD_W - DATA_W)'(0), index_scale_reg};
        b_addr_reg  <= a_addr_reg;
        b_color_reg <= a_color_reg;
    end

    // Cap, offset, round and clamp to a table index
    logic [U_W-1:0]   prod_capped;
    logic [U_W-1:0]   idx_wide;
    logic             idx_low;
    logic             idx_high;
    logic             idx_sat;
    logic [IDX_W-1:0] idx;

    assign prod_capped = (b_prod_reg > PROD_W'(PROD_CAP)) ? PROD_CAP
                                                          : b_prod_reg[U_W-1:0];
    assign idx_wide = b_neg_reg ? (ROUND_BASE - prod_capped)
                                : (ROUND_BASE + prod_capped);
    // an index of exactly -0.5 rounds away from zero to -1
    assign idx_low  = idx_wide[U_W-1] || (idx_wide == '0);
    assign idx_high = !idx_low && (idx_wide[U_W-2:FRAC_W] >= HI_W'(TABLE_ENTRIES));
    assign idx_sat  = idx_low || idx_high;

    always_comb begin
        if (idx_low) begin
            idx = '0;
        end else if (idx_high) begin
            idx = IDX_W'(TABLE_ENTRIES - 1);
        end else begin
            idx = idx_wide[FRAC_W+IDX_W-1:FRAC_W];
        end
    end

    // Color table: writes and reads both issue from stage B, so order is kept
    logic              tbl_we;
    logic              tbl_re;
    logic [DATA_W-1:0] tbl_rdata;

    assign tbl_we = b_valid_reg && (b_func_reg == FUNC_WRITE);
    assign tbl_re = b_valid_reg && (b_func_reg == FUNC_MAP) && !b_bin_reg;

    wlcm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_color_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (b_addr_reg[IDX_W-1:0]),
        .wdata (b_color_reg),
        .re    (tbl_re),
        .raddr (idx),
        .rdata (tbl_rdata)
    );

    // Stage C: table data returns, result selected
    logic              c_valid_reg;
    logic              c_use_tbl_reg;
    logic              c_sat_reg;
    logic [DATA_W-1:0] c_color_reg;
    out_item_t         push_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg && (b_func_reg == FUNC_MAP);
        end
    end

    always_ff @(posedge aclk) begin
        c_use_tbl_reg <= !b_bin_reg;
        c_sat_reg     <= !b_bin_reg && idx_sat;
        c_color_reg   <= b_color_reg;
    end

    assign push_item.pixel_color = c_use_tbl_reg ? tbl_rdata : c_color_reg;
    assign push_item.saturated   = c_sat_reg;

    // Result queue
    out_item_t             fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_next;

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (c_valid_reg && !m_fire) begin
            fifo_cnt_next = fifo_cnt_reg + FIFO_CNT_W'(1);
        end else if (!c_valid_reg && m_fire) begin
            fifo_cnt_next = fifo_cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (c_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg) begin
            fifo_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign m_valid = (fifo_cnt_reg != '0);
    assign m_data  = fifo_mem_reg[rd_ptr_reg];

`ifndef SYNTH
    // Outstanding results never exceed the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result credit count overflow");

    // Queued results are a subset of outstanding ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= occ_reg)
        else $error("result queue holds more than outstanding results");

    // A push never lands on a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (fifo_cnt_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("push into full result queue");

    // A map beat reaches the queue through the stage A, B and C valid registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        map_fire |-> ##3 c_valid_reg)
        else $error("map beat lost in pipeline");

    // Binary mode results never report saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !c_use_tbl_reg) |-> !c_sat_reg)
        else $error("saturation flagged in binary mode");
`endif

endmodule
